>>> hw/rtl/tps_pkg.sv
// ----------------------------------------------------------------------------
// tps_pkg: shared types and constants of the TPS signalling decoder
// Frame layout, sample widths, symbol event and snapshot types, BCH table.
// ----------------------------------------------------------------------------
package tps_pkg;

  localparam int MaxCarriers = 128;
  localparam int SampleBits  = 16;
  localparam int AddrW       = $clog2(MaxCarriers);
  localparam int CntW        = $clog2(MaxCarriers + 1);
  localparam int VoteW       = CntW + 1;
  localparam int ProdW       = 2 * SampleBits;
  localparam int FrameBits   = 68;
  localparam int LastIndex   = 67;
  localparam int FillW       = 7;
  localparam int BchInBits   = 53;
  localparam int BchParBits  = 14;

  // Sync word, bit n of the constant is window position n.
  localparam logic [16:1] SyncBits = 16'b0111_0111_1010_1100;

  typedef struct packed {
    logic has_bit;
    logic bit_val;
  } ev_t;

  typedef struct packed {
    logic       lock_seen;
    logic       frame_valid;
    logic [6:0] sym_pos;
    logic [1:0] constellation;
    logic [2:0] hp_code_rate;
    logic [2:0] lp_code_rate;
    logic [1:0] guard_code;
    logic       transmission_mode;
    logic [1:0] hierarchy_code;
    logic [1:0] frame_num;
    logic [7:0] cell_id;
  } snap_t;

  // Syndrome contribution of each window bit 1..53 to the parity register.
  // Slice (i-1) of the result belongs to window position i.
  function automatic logic [BchInBits*BchParBits-1:0] bch_table();
    logic [BchInBits*BchParBits-1:0] tab;
    logic [BchParBits-1:0] r;
    logic fb;
    tab = '0;
    for (int i = 1; i <= BchInBits; i++) begin
      r = '0;
      for (int j = 1; j <= BchInBits; j++) begin
        fb = (j == i) ^ r[0];
        r  = r >> 1;
        r[13] = r[13] | fb;
        r[12] = r[12] ^ fb;
        r[11] = r[11] ^ fb;
        r[9]  = r[9] ^ fb;
        r[8]  = r[8] ^ fb;
        r[7]  = r[7] ^ fb;
        r[5]  = r[5] ^ fb;
        r[4]  = r[4] ^ fb;
      end
      tab[(i-1)*BchParBits +: BchParBits] = r;
    end
    return tab;
  endfunction

  localparam logic [BchInBits*BchParBits-1:0] BchTab = bch_table();

endpackage

>>> hw/rtl/tps_signalling_decoder.sv
// ----------------------------------------------------------------------------
// tps_signalling_decoder: DVB-T TPS decoder top level
// Carrier front end, symbol event queue and frame engine.
// ----------------------------------------------------------------------------
// Carriers enter as requests on a queue-style port: a request is taken at a
// rising edge with push high and full low. Each carrier carries its I/Q pair
// and a flag on the last TPS carrier of its symbol. Every last carrier yields
// exactly one result, a snapshot of the decoded TPS parameters, read from a
// queue-style port: the oldest result is shown while empty is low and is
// taken at an edge with pop high.
// One carrier is taken in every cycle while full is low. A result passes
// from the edge that takes its last carrier through the previous-symbol
// memory read, the two product registers, the event queue and the frame
// check into the result buffer. Throughput is one carrier per cycle while
// full is low, as the memory is read and written once per carrier and the
// engine takes one symbol event per cycle while the result buffer has room.
// When the reader stalls, the two-entry result buffer and the two-entry
// event queue fill; full then rises only when a symbol end cannot be passed
// on, so carriers in the middle of a symbol keep flowing until then.
// After reset the lock is dropped, the window is empty and every result field
// reads zero until the first lock; the carrier memory needs no clearing, as
// no bit is voted until a symbol of matching length has been stored.
// ----------------------------------------------------------------------------
module tps_signalling_decoder import tps_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push,
  output logic                  full,
  input  logic [SampleBits-1:0] carrier_re_i,
  input  logic [SampleBits-1:0] carrier_im_i,
  input  logic                  last_carrier_i,
  output logic                  empty,
  input  logic                  pop,
  output logic                  lock_seen_o,
  output logic                  frame_valid_o,
  output logic [6:0]            sym_pos_o,
  output logic [1:0]            constellation_o,
  output logic [2:0]            hp_code_rate_o,
  output logic [2:0]            lp_code_rate_o,
  output logic [1:0]            guard_code_o,
  output logic                  transmission_mode_o,
  output logic [1:0]            hierarchy_code_o,
  output logic [1:0]            frame_num_o,
  output logic [7:0]            cell_id_o
);

  logic  ev_wr, ev_full, ev_empty, ev_rd;
  ev_t   ev_in, ev_out;
  snap_t res;

  // Front end: classifies each carrier and produces one event per symbol.
  tps_front u_front (
    .clk_i, .rst_ni, .push, .full,
    .carrier_re_i, .carrier_im_i, .last_carrier_i,
    .ev_valid_o (ev_wr),
    .ev_o       (ev_in),
    .ev_full_i  (ev_full)
  );

  tps_evq u_evq (
    .clk_i, .rst_ni,
    .wr_i    (ev_wr),
    .wdata_i (ev_in),
    .full_o  (ev_full),
    .rd_i    (ev_rd),
    .rdata_o (ev_out),
    .empty_o (ev_empty)
  );

  // Frame engine: window, check and lock, one event per cycle while the result buffer has room.
  tps_back u_back (
    .clk_i, .rst_ni,
    .ev_empty_i (ev_empty),
    .ev_i       (ev_out),
    .ev_rd_o    (ev_rd),
    .pop, .empty,
    .res_o      (res)
  );

  assign lock_seen_o         = res.lock_seen;
  assign frame_valid_o       = res.frame_valid;
  assign sym_pos_o           = res.sym_pos;
  assign constellation_o     = res.constellation;
  assign hp_code_rate_o      = res.hp_code_rate;
  assign lp_code_rate_o      = res.lp_code_rate;
  assign guard_code_o        = res.guard_code;
  assign transmission_mode_o = res.transmission_mode;
  assign hierarchy_code_o    = res.hierarchy_code;
  assign frame_num_o         = res.frame_num;
  assign cell_id_o           = res.cell_id;

endmodule

>>> hw/rtl/tps_front.sv
// ----------------------------------------------------------------------------
// tps_front: carrier front end
// Differential demodulation against the stored previous symbol and voting.
// ----------------------------------------------------------------------------
module tps_front import tps_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push,
  output logic                  full,
  input  logic [SampleBits-1:0] carrier_re_i,
  input  logic [SampleBits-1:0] carrier_im_i,
  input  logic                  last_carrier_i,
  output logic                  ev_valid_o,
  output ev_t                   ev_o,
  input  logic                  ev_full_i
);

  logic [2*SampleBits-1:0] mem [MaxCarriers];
  logic [2*SampleBits-1:0] rd_q;

  logic [CntW-1:0] cnt_q, prev_q, cnt_next;
  logic            counted, accept, stall, match;

  logic                         s1_v_q, s1_last_q, s1_cnt_q, s1_match_q;
  logic signed [SampleBits-1:0] s1_re_q, s1_im_q;
  logic                         s2_v_q, s2_last_q, s2_cnt_q, s2_match_q;
  logic signed [ProdW-1:0]      p_re_q, p_im_q;
  logic signed [VoteW-1:0]      vote_q, vote_d, delta;
  logic signed [ProdW:0]        dot;

  assign stall   = s2_v_q & s2_last_q & ev_full_i;
  assign full    = stall;
  assign accept  = push & ~stall;
  assign counted = cnt_q < CntW'(MaxCarriers);
  assign cnt_next = counted ? cnt_q + 1'b1 : cnt_q;
  assign match   = (prev_q == cnt_next);

  always_ff @(posedge clk_i) begin
    if (accept) begin
      rd_q <= mem[cnt_q[AddrW-1:0]];
      if (counted) begin
        mem[cnt_q[AddrW-1:0]] <= {carrier_re_i, carrier_im_i};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      prev_q <= '0;
    end else if (accept) begin
      if (last_carrier_i) begin
        prev_q <= cnt_next;
        cnt_q  <= '0;
      end else begin
        cnt_q <= cnt_next;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (!stall) begin
      s1_last_q  <= last_carrier_i;
      s1_cnt_q   <= counted;
      s1_match_q <= match;
      s1_re_q    <= signed'(carrier_re_i);
      s1_im_q    <= signed'(carrier_im_i);
      s2_last_q  <= s1_last_q;
      s2_cnt_q   <= s1_cnt_q;
      s2_match_q <= s1_match_q;
      p_re_q     <= s1_re_q * signed'(rd_q[2*SampleBits-1:SampleBits]);
      p_im_q     <= s1_im_q * signed'(rd_q[SampleBits-1:0]);
    end
  end

  assign dot    = (ProdW+1)'(p_re_q) + (ProdW+1)'(p_im_q);
  assign delta  = !s2_cnt_q ? '0 : (dot[ProdW] ? -VoteW'(1) : VoteW'(1));
  assign vote_d = vote_q + delta;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
      vote_q <= '0;
    end else if (!stall) begin
      s1_v_q <= accept;
      s2_v_q <= s1_v_q;
      if (s2_v_q) begin
        vote_q <= s2_last_q ? '0 : vote_d;
      end
    end
  end

  assign ev_valid_o  = s2_v_q & s2_last_q & ~stall;
  assign ev_o.has_bit = s2_match_q;
  assign ev_o.bit_val = vote_d[VoteW-1];

endmodule

>>> hw/rtl/tps_evq.sv
// ----------------------------------------------------------------------------
// tps_evq: symbol event queue
// Two-entry queue of symbol events between the front end and the frame engine.
// ----------------------------------------------------------------------------
module tps_evq import tps_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic wr_i,
  input  ev_t  wdata_i,
  output logic full_o,
  input  logic rd_i,
  output ev_t  rdata_o,
  output logic empty_o
);

  ev_t        slot_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;
  logic       do_wr, do_rd;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign do_wr   = wr_i & ~full_o;
  assign do_rd   = rd_i & ~empty_o;
  assign rdata_o = slot_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      slot_q[wp_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= '0;
    end else begin
      if (do_wr) wp_q <= ~wp_q;
      if (do_rd) rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, do_wr} - {1'b0, do_rd};
    end
  end

endmodule

>>> hw/rtl/tps_back.sv
// ----------------------------------------------------------------------------
// tps_back: frame engine
// Bit window, frame check, lock tracking and the result buffer.
// ----------------------------------------------------------------------------
module tps_back import tps_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  ev_empty_i,
  input  ev_t   ev_i,
  output logic  ev_rd_o,
  input  logic  pop,
  output logic  empty,
  output snap_t res_o
);

  logic [FrameBits-1:0] win_q, win_d;
  logic [FillW-1:0]     fill_q, fill_d;
  logic                 lock_q, lock_d;
  snap_t                snap_q, snap_d, fresh;
  logic [6:0]           idx_d;
  logic [BchParBits-1:0] syn;
  logic                 take, do_check, sync_ok, legal, pass;

  snap_t      ob_q [2];
  logic       wp_q, rp_q, ob_pop;
  logic [1:0] ob_cnt_q;

  assign take    = ~ev_empty_i & (ob_cnt_q != 2'd2);
  assign ev_rd_o = take;

  always_comb begin
    win_d  = win_q;
    fill_d = fill_q;
    if (fill_q < FillW'(FrameBits)) begin
      win_d[fill_q] = ev_i.bit_val;
      fill_d        = fill_q + 1'b1;
    end else begin
      win_d = {ev_i.bit_val, win_q[FrameBits-1:1]};
    end
  end

  always_comb begin
    syn = '0;
    for (int i = 1; i <= BchInBits; i++) begin
      if (win_d[i]) syn = syn ^ BchTab[(i-1)*BchParBits +: BchParBits];
    end
  end

  assign sync_ok = (win_d[16:1] == SyncBits) || (win_d[16:1] == ~SyncBits);
  assign legal   = ({win_d[25], win_d[26]} != 2'd3) && !win_d[27] &&
                   ({win_d[30], win_d[31], win_d[32]} <= 3'd4) &&
                   ({win_d[33], win_d[34], win_d[35]} <= 3'd4) && !win_d[38];
  assign pass    = (fill_d == FillW'(FrameBits)) && sync_ok && legal &&
                   (win_d[67:54] == syn);

  always_comb begin
    fresh.lock_seen         = 1'b1;
    fresh.frame_valid       = 1'b1;
    fresh.sym_pos           = 7'(LastIndex);
    fresh.constellation     = {win_d[25], win_d[26]};
    fresh.hp_code_rate      = {win_d[30], win_d[31], win_d[32]};
    fresh.lp_code_rate      = {win_d[33], win_d[34], win_d[35]};
    fresh.guard_code        = {win_d[36], win_d[37]};
    fresh.transmission_mode = win_d[39];
    fresh.hierarchy_code    = {win_d[28], win_d[29]};
    fresh.frame_num         = {win_d[23], win_d[24]};
    fresh.cell_id           = {win_d[40], win_d[41], win_d[42], win_d[43],
                               win_d[44], win_d[45], win_d[46], win_d[47]};
  end

  always_comb begin
    snap_d = snap_q;
    lock_d = lock_q;
    idx_d  = snap_q.sym_pos;
    if (lock_q) begin
      idx_d = (snap_q.sym_pos == 7'(LastIndex)) ? '0 : snap_q.sym_pos + 1'b1;
    end
    snap_d.sym_pos = idx_d;
    do_check = !lock_q || (idx_d == 7'(LastIndex));
    if (do_check && pass) begin
      snap_d = fresh;
      lock_d = 1'b1;
    end else if (do_check && lock_q) begin
      snap_d.frame_valid = 1'b0;
      lock_d = 1'b0;
    end
    if (!ev_i.has_bit) begin
      snap_d = snap_q;
      lock_d = lock_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q  <= '0;
      fill_q <= '0;
      lock_q <= 1'b0;
      snap_q <= '0;
    end else if (take) begin
      lock_q <= lock_d;
      snap_q <= snap_d;
      if (ev_i.has_bit) begin
        win_q  <= win_d;
        fill_q <= fill_d;
      end
    end
  end

  // Result buffer: two entries so that a stalled reader does not stop the engine until both are full.
  assign empty  = (ob_cnt_q == 2'd0);
  assign ob_pop = pop & ~empty;
  assign res_o  = ob_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (take) begin
      ob_q[wp_q] <= snap_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q     <= 1'b0;
      rp_q     <= 1'b0;
      ob_cnt_q <= '0;
    end else begin
      if (take)   wp_q <= ~wp_q;
      if (ob_pop) rp_q <= ~rp_q;
      ob_cnt_q <= ob_cnt_q + {1'b0, take} - {1'b0, ob_pop};
    end
  end

endmodule

>>> hw/rtl/tps_checker.sv
// ----------------------------------------------------------------------------
// tps_checker: port-level checks of the TPS decoder
// Watches the result port and is bound to the top level.
// ----------------------------------------------------------------------------
module tps_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       empty,
  input logic       pop,
  input logic       lock_seen_o,
  input logic       frame_valid_o,
  input logic [6:0] sym_pos_o,
  input logic [1:0] constellation_o,
  input logic [7:0] cell_id_o
);

  a_index_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> sym_pos_o <= 7'd67)
    else $error("symbol index beyond frame length");

  a_valid_locked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && frame_valid_o |-> lock_seen_o)
    else $error("valid frame reported without lock");

  a_zero_unlocked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && !lock_seen_o |->
      sym_pos_o == 7'd0 && constellation_o == 2'd0 && cell_id_o == 8'd0)
    else $error("fields set before first lock");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && !pop |=> !empty && $stable(sym_pos_o) && $stable(cell_id_o))
    else $error("stalled result changed");

endmodule

bind tps_signalling_decoder tps_checker u_tps_checker (.*);
